>>> rtl/core/sblk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sblk_pkg
// Shared types and constants for the sorted book lookup block.
// ----------------------------------------------------------------------------
package sblk_pkg;

   localparam int unsigned TableDepthDefault = 4096;
   localparam int unsigned CountWidth        = 13;
   localparam int unsigned KeyWidth          = 64;
   localparam int unsigned MoveWidth         = 16;
   localparam int unsigned WeightWidth       = 16;
   localparam int unsigned RandWidth         = 32;
   localparam int unsigned PosWidth          = 12;
   localparam int unsigned CsrIndexWidth     = 1;

   localparam logic [CsrIndexWidth-1:0] CSR_ENTRY_COUNT = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CSR_RANDOM_SEED = 1'b1;

   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_WALK_RD,
      ST_WALK_CMP,
      ST_MOD,
      ST_PICK_RD,
      ST_PICK_WAIT,
      ST_OUT
   } state_type;

   function automatic logic [RandWidth-1:0] xorshift(input logic [RandWidth-1:0] s);
      logic [RandWidth-1:0] t;
      t = s ^ (s << 13);
      t = t ^ (t >> 17);
      t = t ^ (t << 5);
      return t;
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/sorted_book_lookup_select_top.sv
`default_nettype none
// A load writes one entry. A query runs a binary search over the table,
// then walks the run of equal keys entry by entry (a weighted pick waits on
// the bit-serial remainder unit for each entry), then reads out the pick.
// One item at a time; req_ready is low while a query is in flight.
// Reset: entry_count 0, seed and generator 1; entry memory not cleared.
// ----------------------------------------------------------------------------
// sorted_book_lookup_select_top
// Sorted table lookup with best or weighted-random pick over equal keys.
// ----------------------------------------------------------------------------
module sorted_book_lookup_select_top #(
   parameter int unsigned TABLE_DEPTH = sblk_pkg::TableDepthDefault
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sblk_pkg::CsrIndexWidth-1:0]   csr_index,
   input  wire logic [sblk_pkg::RandWidth-1:0]       csr_write_data,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic                                 req_type,
   input  wire logic [sblk_pkg::PosWidth-1:0]        req_entry_index,
   input  wire logic [sblk_pkg::KeyWidth-1:0]        req_entry_key,
   input  wire logic [sblk_pkg::MoveWidth-1:0]       req_entry_move,
   input  wire logic [sblk_pkg::WeightWidth-1:0]     req_entry_weight,
   input  wire logic [sblk_pkg::KeyWidth-1:0]        req_query_key,
   input  wire logic                                 req_best_mode,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic                                      rsp_found,
   output logic      [sblk_pkg::MoveWidth-1:0]       rsp_move_code,
   output logic      [sblk_pkg::PosWidth-1:0]        rsp_entry_position,
   output logic      [sblk_pkg::WeightWidth-1:0]     rsp_chosen_weight
);

   localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int unsigned IW = AW + 1;  // index wide enough to hold depth
   localparam int unsigned PW = sblk_pkg::PosWidth;
   localparam int unsigned RW = sblk_pkg::RandWidth;
   localparam int unsigned WW = sblk_pkg::WeightWidth;
   localparam int unsigned CW = sblk_pkg::CountWidth;
   localparam int unsigned DW = (CW > IW) ? CW : IW;

   sblk_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff;
   logic [RW-1:0]                    rand_ff, rand_in;
   logic [IW-1:0]                    n_ff, n_in;
   logic [IW-1:0]                    lo_ff, lo_in, hi_ff, hi_in, idx_ff, idx_in;
   logic [IW-1:0]                    pick_ff, pick_in, mid;
   logic [sblk_pkg::KeyWidth-1:0]    q_ff, q_in;
   logic                             best_ff, best_in;
   logic [WW-1:0]                    top_ff, top_in, w_ff, w_in;
   logic [RW-1:0]                    sum_ff, sum_in;
   logic                             found_ff, found_in;
   logic [sblk_pkg::MoveWidth-1:0]   o_move_ff, o_move_in;
   logic [PW-1:0]                    o_pos_ff, o_pos_in;
   logic [WW-1:0]                    o_w_ff, o_w_in;
   logic                             o_valid_ff, o_valid_in;

   logic [AW-1:0]                    rd_addr;
   logic [sblk_pkg::KeyWidth-1:0]    rd_key;
   logic [sblk_pkg::MoveWidth-1:0]   rd_move;
   logic [WW-1:0]                    rd_weight;
   logic                             wr_en;
   logic                             mod_start, mod_done;
   logic [RW-1:0]                    mod_rem, r_next;
   logic [RW:0]                      sum_wide;
   logic [DW-1:0]                    count_ext;

   assign wr_en = req_valid && req_ready && req_type == sblk_pkg::REQ_LOAD
                  && {{(DW-PW){1'b0}}, req_entry_index} < DW'(TABLE_DEPTH);

   sblk_store #(.AW(AW)) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (AW'(req_entry_index)),
      .wr_key    (req_entry_key),
      .wr_move   (req_entry_move),
      .wr_weight (req_entry_weight),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_move   (rd_move),
      .rd_weight (rd_weight)
   );

   sblk_modu u_modu (
      .clock     (clock),
      .reset     (reset),
      .start     (mod_start),
      .dividend  (rand_ff),
      .divisor   (sum_ff),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   assign mid       = IW'(lo_ff + ((hi_ff - lo_ff) >> 1));
   assign r_next    = sblk_pkg::xorshift(rand_ff);
   assign sum_wide  = {1'b0, sum_ff} + {{(RW+1-WW){1'b0}}, rd_weight};
   assign count_ext = DW'(count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sblk_pkg::ST_IDLE;
         count_ff   <= '0;
         rand_ff    <= RW'(1);
         o_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         o_valid_ff <= o_valid_in;
         rand_ff    <= rand_in;
         if (csr_write_enable && csr_index == sblk_pkg::CSR_ENTRY_COUNT) begin
            count_ff <= csr_write_data[CW-1:0];
         end
      end
      n_ff      <= n_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      idx_ff    <= idx_in;
      pick_ff   <= pick_in;
      q_ff      <= q_in;
      best_ff   <= best_in;
      top_ff    <= top_in;
      w_ff      <= w_in;
      sum_ff    <= sum_in;
      found_ff  <= found_in;
      o_move_ff <= o_move_in;
      o_pos_ff  <= o_pos_in;
      o_w_ff    <= o_w_in;
   end

   always_comb begin
      state_in   = state_ff;
      rand_in    = rand_ff;
      n_in       = n_ff;
      lo_in      = lo_ff;
      hi_in      = hi_ff;
      idx_in     = idx_ff;
      pick_in    = pick_ff;
      q_in       = q_ff;
      best_in    = best_ff;
      top_in     = top_ff;
      w_in       = w_ff;
      sum_in     = sum_ff;
      found_in   = found_ff;
      o_move_in  = o_move_ff;
      o_pos_in   = o_pos_ff;
      o_w_in     = o_w_ff;
      o_valid_in = o_valid_ff;
      rd_addr    = AW'(idx_ff);
      mod_start  = 1'b0;
      req_ready  = 1'b0;
      if (csr_write_enable && csr_index == sblk_pkg::CSR_RANDOM_SEED) begin
         rand_in = csr_write_data;
      end
      if (o_valid_ff && rsp_ready) begin
         o_valid_in = 1'b0;
      end
      case (state_ff)
         sblk_pkg::ST_IDLE: begin
            req_ready = !o_valid_ff;
            if (req_valid && req_ready && req_type == sblk_pkg::REQ_QUERY) begin
               q_in    = req_query_key;
               best_in = req_best_mode;
               n_in    = (count_ext > DW'(TABLE_DEPTH)) ? IW'(TABLE_DEPTH) : IW'(count_ff);
               lo_in   = '0;
               hi_in   = IW'(n_in - 1'b1);
               top_in  = '0;
               sum_in  = '0;
               found_in  = 1'b0;
               o_move_in = '0;
               o_pos_in  = '0;
               o_w_in    = '0;
               if (n_in == '0) begin
                  state_in = sblk_pkg::ST_OUT;
               end else begin
                  state_in = sblk_pkg::ST_SRCH_RD;
               end
            end
         end
         sblk_pkg::ST_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               rd_addr  = AW'(mid);
               idx_in   = mid;
            end else begin
               rd_addr  = AW'(lo_ff);
               idx_in   = lo_ff;
            end
            state_in = sblk_pkg::ST_SRCH_CMP;
         end
         sblk_pkg::ST_SRCH_CMP: begin
            if (lo_ff < hi_ff) begin
               if (q_ff <= rd_key) begin
                  hi_in = idx_ff;
               end else begin
                  lo_in = IW'(idx_ff + 1'b1);
               end
               state_in = sblk_pkg::ST_SRCH_RD;
            end else if (rd_key != q_ff) begin
               state_in = sblk_pkg::ST_OUT;
            end else begin
               // leftmost match: start walking the run here
               pick_in  = lo_ff;
               found_in = 1'b1;
               idx_in   = lo_ff;
               state_in = sblk_pkg::ST_WALK_RD;
            end
         end
         sblk_pkg::ST_WALK_RD: begin
            if (idx_ff < n_ff) begin
               state_in = sblk_pkg::ST_WALK_CMP;
            end else begin
               state_in = sblk_pkg::ST_PICK_RD;
            end
         end
         sblk_pkg::ST_WALK_CMP: begin
            if (rd_key != q_ff) begin
               state_in = sblk_pkg::ST_PICK_RD;
            end else if (best_ff) begin
               if (rd_weight > top_ff) begin
                  top_in  = rd_weight;
                  pick_in = idx_ff;
               end
               idx_in   = IW'(idx_ff + 1'b1);
               state_in = sblk_pkg::ST_WALK_RD;
            end else begin
               rand_in = r_next;
               sum_in  = sum_wide[RW] ? {RW{1'b1}} : sum_wide[RW-1:0];
               w_in    = rd_weight;
               state_in = sblk_pkg::ST_MOD;
            end
         end
         sblk_pkg::ST_MOD: begin
            // first cycle here kicks off the remainder unit, unless sum or weight is zero
            if (sum_ff == '0) begin
               idx_in   = IW'(idx_ff + 1'b1);
               state_in = sblk_pkg::ST_WALK_RD;
            end else if (!mod_done && w_ff != WW'(0) && top_ff == '0) begin
               mod_start = 1'b1;
               top_in    = WW'(1);
            end else if (mod_done) begin
               if (mod_rem < {{(RW-WW){1'b0}}, w_ff}) begin
                  pick_in = idx_ff;
               end
               top_in   = '0;
               idx_in   = IW'(idx_ff + 1'b1);
               state_in = sblk_pkg::ST_WALK_RD;
            end else if (w_ff == '0) begin
               idx_in   = IW'(idx_ff + 1'b1);
               state_in = sblk_pkg::ST_WALK_RD;
            end
         end
         sblk_pkg::ST_PICK_RD: begin
            rd_addr  = AW'(pick_ff);
            state_in = sblk_pkg::ST_PICK_WAIT;
         end
         sblk_pkg::ST_PICK_WAIT: begin
            o_move_in = rd_move;
            o_pos_in  = PW'(pick_ff);
            o_w_in    = rd_weight;
            state_in  = sblk_pkg::ST_OUT;
         end
         sblk_pkg::ST_OUT: begin
            if (!o_valid_ff) begin
               o_valid_in = 1'b1;
               state_in   = sblk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sblk_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid          = o_valid_ff;
   assign rsp_found          = found_ff;
   assign rsp_move_code      = o_move_ff;
   assign rsp_entry_position = o_pos_ff;
   assign rsp_chosen_weight  = o_w_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != sblk_pkg::ST_IDLE) |-> !req_ready)
      else $error("request taken while query in flight");
   a_search_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sblk_pkg::ST_SRCH_RD) |-> (lo_ff <= hi_ff && hi_ff < n_ff))
      else $error("search window out of range");
   a_notfound_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_move_code == '0 && rsp_chosen_weight == '0))
      else $error("miss carries nonzero payload");
`endif

endmodule
`default_nettype wire

>>> rtl/core/sblk_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sblk_store
// Entry memory: key, move and weight, one write and one registered read port.
// ----------------------------------------------------------------------------
module sblk_store #(
   parameter int unsigned AW = 12
) (
   input  wire logic                               clock,
   input  wire logic                               wr_en,
   input  wire logic [AW-1:0]                      wr_addr,
   input  wire logic [sblk_pkg::KeyWidth-1:0]      wr_key,
   input  wire logic [sblk_pkg::MoveWidth-1:0]     wr_move,
   input  wire logic [sblk_pkg::WeightWidth-1:0]   wr_weight,
   input  wire logic [AW-1:0]                      rd_addr,
   output logic      [sblk_pkg::KeyWidth-1:0]      rd_key,
   output logic      [sblk_pkg::MoveWidth-1:0]     rd_move,
   output logic      [sblk_pkg::WeightWidth-1:0]   rd_weight
);

   localparam int unsigned DataWidth =
      sblk_pkg::KeyWidth + sblk_pkg::MoveWidth + sblk_pkg::WeightWidth;

   logic [DataWidth-1:0] mem [2**AW];
   logic [DataWidth-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_key, wr_move, wr_weight};
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_weight = rd_data_ff[sblk_pkg::WeightWidth-1:0];
   assign rd_move   = rd_data_ff[sblk_pkg::WeightWidth +: sblk_pkg::MoveWidth];
   assign rd_key    = rd_data_ff[DataWidth-1 -: sblk_pkg::KeyWidth];

endmodule
`default_nettype wire

>>> rtl/core/sblk_modu.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sblk_modu
// Iterative 32-bit remainder, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sblk_modu (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [sblk_pkg::RandWidth-1:0]   dividend,
   input  wire logic [sblk_pkg::RandWidth-1:0]   divisor,
   output logic                                  done,
   output logic      [sblk_pkg::RandWidth-1:0]   remainder
);

   localparam int unsigned W = sblk_pkg::RandWidth;

   logic [W-1:0]        rem_ff, rem_in;
   logic [W-1:0]        quo_ff, quo_in;
   logic [W-1:0]        div_ff, div_in;
   logic [$clog2(W):0]  cnt_ff, cnt_in;
   logic                busy_ff, busy_in;
   logic [W:0]          trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      trial   = {rem_ff, quo_ff[W-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         div_in  = divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = quo_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = W'(trial - {1'b0, div_ff});
         end else begin
            rem_in = trial[W-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ($clog2(W)+1)'(W-1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign done      = busy_ff && !busy_in && !start;
   assign remainder = rem_in;

endmodule
`default_nettype wire
